// ===== rtl/lbrp_pkg.sv =====
`default_nettype none

package lbrp_pkg;

   // field and register widths
   localparam int COUNT_W   = 32;
   localparam int CAP_W     = 32;
   localparam int MAXW_W    = 7;
   localparam int LOAD_W    = 64;
   localparam int BEGIN_W   = 16;
   localparam int END_W     = 17;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_IDX_W  = 1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_LOAD_CAP    = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_WINDOWS = 1'b1;

   // reset values
   localparam logic [CAP_W-1:0]  LOAD_CAP_RST    = '0;
   localparam logic [MAXW_W-1:0] MAX_WINDOWS_RST = 7'd1;

   // clustering weight 16 = shift by 4
   localparam int CLUSTER_SHIFT = 4;

   // divider: one quotient bit per step over the 64-bit remaining load
   localparam int DIV_STEPS = LOAD_W;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   // parameter defaults
   localparam int DEF_MAX_TERMS   = 65536;
   localparam int DEF_MAX_WINDOWS = 64;

   typedef struct packed {
      logic load;      // store one count, add its load
      logic start;     // latch set, clear accumulators
      logic win_init;  // set up next window
      logic div_step;  // one divider step
      logic rd_issue;  // read count at end pointer
      logic acc;       // add term load, advance end
      logic close;     // subtract window load from remaining
      logic emit;      // push window into output register
   } lbrp_cmd_type;

   typedef struct packed {
      logic dim_zero;   // no terms stored
      logic single;     // one window left: takes the rest
      logic div_done;   // last divider step
      logic walk_go;    // window still growing
      logic out_free;   // output register can take a window
      logic final_win;  // current window reaches the last term
   } lbrp_sts_type;

   function automatic logic [LOAD_W-1:0] term_load(input logic [COUNT_W-1:0] count,
                                                   input logic [CAP_W-1:0]   cap);
      logic [COUNT_W-1:0] capped;
      capped = (count < cap) ? count : cap;
      return LOAD_W'(count) + (LOAD_W'(capped) << CLUSTER_SHIFT);
   endfunction

endpackage

`default_nettype wire

// ===== rtl/lbrp_if.sv =====
`default_nettype none

interface lbrp_req_if;
   import lbrp_pkg::*;

   logic               valid;
   logic               ready;
   logic [COUNT_W-1:0] term_count;
   logic               last_term;

   modport source (output valid, output term_count, output last_term, input ready);
   modport sink   (input valid, input term_count, input last_term, output ready);
endinterface

interface lbrp_rsp_if;
   import lbrp_pkg::*;

   logic               valid;
   logic               ready;
   logic [BEGIN_W-1:0] window_begin;
   logic [END_W-1:0]   window_end;
   logic               last_window;

   modport source (output valid, output window_begin, output window_end,
                   output last_window, input ready);
   modport sink   (input valid, input window_begin, input window_end,
                   input last_window, output ready);
endinterface

`default_nettype wire

// ===== rtl/lbrp_ctrl.sv =====
`default_nettype none

module lbrp_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   input  wire logic                  req_last,
   output logic                       req_ready,
   input  wire lbrp_pkg::lbrp_sts_type sts,
   output lbrp_pkg::lbrp_cmd_type      cmd
);
   import lbrp_pkg::*;

   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_START = 7'b0000010,
      S_WIN   = 7'b0000100,
      S_DIV   = 7'b0001000,
      S_RD    = 7'b0010000,
      S_ACC   = 7'b0100000,
      S_EMIT  = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               if (req_last) state_in = S_START;
            end
         end
         S_START: begin
            cmd.start = 1'b1;
            state_in  = sts.dim_zero ? S_IDLE : S_WIN;
         end
         S_WIN: begin
            cmd.win_init = 1'b1;
            state_in     = sts.single ? S_EMIT : S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_done) state_in = S_RD;
         end
         S_RD: begin
            if (sts.walk_go) begin
               cmd.rd_issue = 1'b1;
               state_in     = S_ACC;
            end else begin
               cmd.close = 1'b1;
               state_in  = S_EMIT;
            end
         end
         S_ACC: begin
            cmd.acc  = 1'b1;
            state_in = S_RD;
         end
         S_EMIT: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               state_in = sts.final_win ? S_IDLE : S_WIN;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end

endmodule

`default_nettype wire

// ===== rtl/lbrp_dp.sv =====
`default_nettype none

module lbrp_dp #(
   parameter int MAX_TERMS   = lbrp_pkg::DEF_MAX_TERMS,
   parameter int MAX_WINDOWS = lbrp_pkg::DEF_MAX_WINDOWS
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire lbrp_pkg::lbrp_cmd_type             cmd,
   output lbrp_pkg::lbrp_sts_type                  sts,
   input  wire logic                              csr_write_en,
   input  wire logic [lbrp_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [lbrp_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  wire logic [lbrp_pkg::COUNT_W-1:0]      term_count,
   output logic                                   out_valid,
   input  wire logic                              out_ready,
   output logic [lbrp_pkg::BEGIN_W-1:0]           out_begin,
   output logic [lbrp_pkg::END_W-1:0]             out_end,
   output logic                                   out_last
);
   import lbrp_pkg::*;

   localparam int TW = $clog2(MAX_TERMS + 1);                 // term count / index
   localparam int AW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1; // store address
   localparam int WW = $clog2(MAX_WINDOWS + 1);               // window count

   // configuration
   logic [CAP_W-1:0]  cap_ff;
   logic [MAXW_W-1:0] maxw_ff;

   // loading
   logic [COUNT_W-1:0] count_mem [MAX_TERMS];
   logic [TW-1:0]      loaded_ff;
   logic [LOAD_W-1:0]  total_ff;
   logic               store_ok;

   // partition walk
   logic [COUNT_W-1:0] rd_ff;
   logic [TW-1:0]      dim_ff, begin_ff, end_ff, maxend_ff;
   logic [LOAD_W-1:0]  remain_ff, load_ff, target_ff, quo_ff;
   logic [WW-1:0]      batches_ff, emitted_ff, left_ff, rem_ff;
   logic [DIV_CNT_W-1:0] divcnt_ff;

   // output register
   logic               out_valid_ff;
   logic [BEGIN_W-1:0] out_begin_ff;
   logic [END_W-1:0]   out_end_ff;
   logic               out_last_ff;

   // combinational helpers
   logic [31:0]       batch_clamp;
   logic [WW-1:0]     left_now;
   logic [WW:0]       div_shift;
   logic              div_ge;
   logic [WW-1:0]     rem_next;
   logic [LOAD_W-1:0] quo_next;

   assign store_ok = loaded_ff < TW'(MAX_TERMS);

   // window count: 0 acts as 1, then limit to MAX_WINDOWS and to term count
   always_comb begin
      batch_clamp = (maxw_ff == '0) ? 32'd1 : 32'(maxw_ff);
      if (batch_clamp > 32'(MAX_WINDOWS)) batch_clamp = 32'(MAX_WINDOWS);
      if (batch_clamp > 32'(loaded_ff))   batch_clamp = 32'(loaded_ff);
   end

   assign left_now = batches_ff - emitted_ff;

   // restoring divider step: remaining / windows left
   assign div_shift = {rem_ff, quo_ff[LOAD_W-1]};
   assign div_ge    = div_shift >= {1'b0, left_ff};
   assign rem_next  = div_ge ? WW'(div_shift - {1'b0, left_ff}) : WW'(div_shift);
   assign quo_next  = {quo_ff[LOAD_W-2:0], div_ge};

   always_comb begin
      sts           = '0;
      sts.dim_zero  = loaded_ff == '0;
      sts.single    = left_now <= WW'(1);
      sts.div_done  = divcnt_ff == DIV_CNT_W'(DIV_STEPS - 1);
      sts.walk_go   = (end_ff < maxend_ff) && ((end_ff == begin_ff) || (load_ff < target_ff));
      sts.out_free  = !out_valid_ff || out_ready;
      sts.final_win = end_ff >= dim_ff;
   end

   // count store
   always_ff @(posedge clock) begin
      if (cmd.load && store_ok) count_mem[loaded_ff[AW-1:0]] <= term_count;
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_issue) rd_ff <= count_mem[end_ff[AW-1:0]];
   end

   // control-side registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff       <= LOAD_CAP_RST;
         maxw_ff      <= MAX_WINDOWS_RST;
         loaded_ff    <= '0;
         total_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               CSR_LOAD_CAP:    cap_ff  <= csr_wdata[CAP_W-1:0];
               CSR_MAX_WINDOWS: maxw_ff <= csr_wdata[MAXW_W-1:0];
               default: ;
            endcase
         end
         if (cmd.load && store_ok) begin
            loaded_ff <= loaded_ff + TW'(1);
            total_ff  <= total_ff + term_load(term_count, cap_ff);
         end else if (cmd.start) begin
            loaded_ff <= '0;
            total_ff  <= '0;
         end
         if (cmd.emit)     out_valid_ff <= 1'b1;
         else if (out_ready) out_valid_ff <= 1'b0;
      end
   end

   // partition walk
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         dim_ff     <= loaded_ff;
         remain_ff  <= total_ff;
         batches_ff <= WW'(batch_clamp);
         emitted_ff <= '0;
         begin_ff   <= '0;
      end
      if (cmd.win_init) begin
         end_ff    <= sts.single ? dim_ff : begin_ff;
         load_ff   <= '0;
         left_ff   <= left_now;
         quo_ff    <= remain_ff;
         rem_ff    <= '0;
         divcnt_ff <= '0;
         maxend_ff <= dim_ff - TW'(left_now - WW'(1));
      end
      if (cmd.div_step) begin
         quo_ff    <= quo_next;
         rem_ff    <= rem_next;
         divcnt_ff <= divcnt_ff + DIV_CNT_W'(1);
         if (sts.div_done) target_ff <= quo_next + LOAD_W'(rem_next != '0);
      end
      if (cmd.acc) begin
         load_ff <= load_ff + term_load(rd_ff, cap_ff);
         end_ff  <= end_ff + TW'(1);
      end
      if (cmd.close) remain_ff <= remain_ff - load_ff;
      if (cmd.emit) begin
         out_begin_ff <= BEGIN_W'(begin_ff);
         out_end_ff   <= END_W'(end_ff);
         out_last_ff  <= sts.final_win;
         emitted_ff   <= emitted_ff + WW'(1);
         begin_ff     <= end_ff;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_begin = out_begin_ff;
   assign out_end   = out_end_ff;
   assign out_last  = out_last_ff;

endmodule

`default_nettype wire

// ===== rtl/load_balanced_range_partitioner.sv =====
`default_nettype none

// Channel   Dir  Handshake          Payload
// req_chan  in   valid/ready        term_count[31:0], last_term
// rsp_chan  out  valid/ready        window_begin[15:0], window_end[16:0], last_window
// csr_*     in   csr_write_en only  csr_index (0 load_cap, 1 max_windows), csr_wdata[31:0]
//
// Counts load at one item per cycle. An item with last_term starts the partition walk,
// during which req_chan.ready is low. Each window with two or more windows left steps
// through setup, the divider (one quotient bit per cycle), a store read then an add per
// term, a close and an emit; the final window has only setup and emit. Reset is
// synchronous and clears the term counter, totals and output valid and resets config;
// the count store is not cleared. A stalled rsp_chan holds the walk in its emit step;
// the last window waits in the output register while new items are taken.

module load_balanced_range_partitioner #(
   parameter int MAX_TERMS   = lbrp_pkg::DEF_MAX_TERMS,
   parameter int MAX_WINDOWS = lbrp_pkg::DEF_MAX_WINDOWS
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_write_en,
   input  wire logic [lbrp_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [lbrp_pkg::CSR_DATA_W-1:0] csr_wdata,
   lbrp_req_if.sink                             req_chan,
   lbrp_rsp_if.source                           rsp_chan
);
   import lbrp_pkg::*;

   lbrp_cmd_type cmd;   // controller -> datapath
   lbrp_sts_type sts;   // datapath -> controller

   // sequencer: load, then per window divide / walk / emit; the last window skips divide and walk
   lbrp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_last  (req_chan.last_term),
      .req_ready (req_chan.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // count store, totals, divider, walk pointers and output register
   lbrp_dp #(
      .MAX_TERMS   (MAX_TERMS),
      .MAX_WINDOWS (MAX_WINDOWS)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .sts          (sts),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .term_count   (req_chan.term_count),
      .out_valid    (rsp_chan.valid),
      .out_ready    (rsp_chan.ready),
      .out_begin    (rsp_chan.window_begin),
      .out_end      (rsp_chan.window_end),
      .out_last     (rsp_chan.last_window)
   );

endmodule

`default_nettype wire
